// ===== rtl/core/hdc_pkg.sv =====
// Shared types, field widths and holiday codes for the holiday date classifier.
// No dependencies; every other file of the block imports this package.
package hdc_pkg;

	// Field widths
	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int CODE_W   = 4;
	localparam int EMONTH_W = 3;
	localparam int CENT_W   = 8;   // year / 100 for any 14-bit year
	localparam int YY_W     = 7;   // year % 100

	// Supported Gregorian year range
	localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1583;
	localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

	// Months
	localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
	localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MON_OCT = 4'd10;
	localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

	localparam logic [EMONTH_W-1:0] EMON_MAR = 3'd3;
	localparam logic [EMONTH_W-1:0] EMON_APR = 3'd4;

	// Holiday codes
	localparam logic [CODE_W-1:0] HC_NONE     = 4'd0;
	localparam logic [CODE_W-1:0] HC_FEB14    = 4'd1;
	localparam logic [CODE_W-1:0] HC_MAR8     = 4'd2;
	localparam logic [CODE_W-1:0] HC_APR22    = 4'd3;
	localparam logic [CODE_W-1:0] HC_JUN19    = 4'd4;
	localparam logic [CODE_W-1:0] HC_OCT31    = 4'd5;
	localparam logic [CODE_W-1:0] HC_DEC25    = 4'd6;
	localparam logic [CODE_W-1:0] HC_MLK      = 4'd7;
	localparam logic [CODE_W-1:0] HC_INDIGENS = 4'd8;
	localparam logic [CODE_W-1:0] HC_EASTER   = 4'd9;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} hdc_date_t;

	typedef struct packed {
		logic [CODE_W-1:0]   holiday_code;
		logic [EMONTH_W-1:0] easter_month;
		logic [DAY_W-1:0]    easter_day;
		logic                range_error;
	} hdc_result_t;

	// Century and year-of-century split, shared by computus and weekday logic
	typedef struct packed {
		logic [CENT_W-1:0] cent;
		logic [YY_W-1:0]   yy;
	} hdc_split_t;

	typedef struct packed {
		logic [EMONTH_W-1:0] month;
		logic [DAY_W-1:0]    day;
	} hdc_easter_t;

	// Day of month of the floating Monday holidays
	typedef struct packed {
		logic [DAY_W-1:0] mlk_day;
		logic [DAY_W-1:0] idp_day;
	} hdc_mondays_t;

endpackage

// ===== rtl/core/holiday_date_classifier.sv =====
// Holiday date classifier.
// A date is transferred in at a rising edge where start is high and busy is
// low. busy stays low: the pipeline takes a new date in every cycle.
// The result for that date is on result for exactly one cycle, marked by
// done, once the date has passed all the register stages below (the result is
// taken at the edge that ends the done pulse). Results leave in the order
// the dates came in, one per cycle at full rate.
// The pipeline has ten register stages: nine of the Easter computus
// (one stage of reciprocal products for /100 and /19, seven more for the
// /25, /3, /30 and /7 reductions and the sums between them, and one that
// splits t into month and day) and a final compare stage for the code.
// result.easter_month/easter_day give Easter Sunday of the year;
// result.range_error flags a year outside 1583..9999 and forces the code
// to none. Month and day are not range checked.
// Reset clears the valid bits of all stages, so no done follows a reset
// until a new date is transferred. The receiver cannot stall the block, and
// there is no back-pressure path.
// Depends on hdc_pkg, hdc_computus and hdc_weekday.
module holiday_date_classifier import hdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  hdc_date_t   date,
	output logic        done,
	output hdc_result_t result
);

	localparam int PIPE_DEPTH = 10;
	localparam int TAG_DEPTH  = 9;

	typedef struct packed {
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic               bad;
	} hdc_tag_t;

	logic [PIPE_DEPTH-1:0] vld_q;
	hdc_tag_t              tag_q [TAG_DEPTH];
	hdc_split_t            split;
	hdc_easter_t           easter;
	hdc_mondays_t          mondays;
	hdc_result_t           result_s10;
	logic [CODE_W-1:0]     code;
	logic                  accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Advance the valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], accept};
		end
	end

	// Carry month, day and the range flag down to the compare stage
	always_ff @(posedge clk) begin
		tag_q[0].month <= date.month;
		tag_q[0].day   <= date.day;
		tag_q[0].bad   <= (date.year < YEAR_MIN) || (date.year > YEAR_MAX);
		for (int n = 1; n < TAG_DEPTH; n++) begin
			tag_q[n] <= tag_q[n-1];
		end
	end

	hdc_computus u_computus (
		.clk    (clk),
		.year   (date.year),
		.split  (split),
		.easter (easter)
	);

	hdc_weekday u_weekday (
		.clk     (clk),
		.split   (split),
		.mondays (mondays)
	);

	// Try the rules in order; the first match wins
	always_comb begin
		priority if (tag_q[TAG_DEPTH-1].bad) begin
			code = HC_NONE;
		end else if (tag_q[TAG_DEPTH-1].month == MON_FEB && tag_q[TAG_DEPTH-1].day == 5'd14) begin
			code = HC_FEB14;
		end else if (tag_q[TAG_DEPTH-1].month == MON_MAR && tag_q[TAG_DEPTH-1].day == 5'd8) begin
			code = HC_MAR8;
		end else if (tag_q[TAG_DEPTH-1].month == MON_APR && tag_q[TAG_DEPTH-1].day == 5'd22) begin
			code = HC_APR22;
		end else if (tag_q[TAG_DEPTH-1].month == MON_JUN && tag_q[TAG_DEPTH-1].day == 5'd19) begin
			code = HC_JUN19;
		end else if (tag_q[TAG_DEPTH-1].month == MON_OCT && tag_q[TAG_DEPTH-1].day == 5'd31) begin
			code = HC_OCT31;
		end else if (tag_q[TAG_DEPTH-1].month == MON_DEC && tag_q[TAG_DEPTH-1].day == 5'd25) begin
			code = HC_DEC25;
		end else if (tag_q[TAG_DEPTH-1].month == MON_JAN
				&& tag_q[TAG_DEPTH-1].day == mondays.mlk_day) begin
			code = HC_MLK;
		end else if (tag_q[TAG_DEPTH-1].month == MON_OCT
				&& tag_q[TAG_DEPTH-1].day == mondays.idp_day) begin
			code = HC_INDIGENS;
		end else if (tag_q[TAG_DEPTH-1].month == MONTH_W'(easter.month)
				&& tag_q[TAG_DEPTH-1].day == easter.day) begin
			code = HC_EASTER;
		end else begin
			code = HC_NONE;
		end
	end

	// Stage 10: register the result
	always_ff @(posedge clk) begin
		result_s10.holiday_code <= code;
		result_s10.easter_month <= easter.month;
		result_s10.easter_day   <= easter.day;
		result_s10.range_error  <= tag_q[TAG_DEPTH-1].bad;
	end

	assign done   = vld_q[PIPE_DEPTH-1];
	assign result = result_s10;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##10 done)
		else $error("transfer not followed by a result after ten cycles");

	a_range_code: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.range_error |-> result.holiday_code == HC_NONE)
		else $error("holiday code set for a year out of range");

	a_easter_month: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.easter_month == EMON_MAR || result.easter_month == EMON_APR))
		else $error("Easter month outside March and April");

	a_easter_april: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.easter_month == EMON_APR |-> result.easter_day <= 5'd26)
		else $error("Easter day in April past the computus bound");
`endif

endmodule

// ===== rtl/core/hdc_computus.sv =====
// Pipelined Easter computus (anonymous Gregorian method), nine register stages.
// Depends on hdc_pkg; also exports the century / year-of-century split at stage 2.
module hdc_computus import hdc_pkg::*; (
	input  logic              clk,
	input  logic [YEAR_W-1:0] year,
	output hdc_split_t        split,
	output hdc_easter_t       easter
);

	// Reciprocals for the constant divisions; each is exact over its input range
	localparam logic [12:0] RCP100 = 13'd5243;   // /100, shift 19
	localparam logic [15:0] RCP19  = 16'd55189;  // /19,  shift 20
	localparam logic [5:0]  RCP25  = 6'd41;      // /25,  shift 10
	localparam logic [7:0]  RCP3   = 8'd171;     // /3,   shift 9
	localparam logic [9:0]  RCP30  = 10'd547;    // /30,  shift 14
	localparam logic [7:0]  RCP7   = 8'd147;     // /7,   shift 10
	localparam logic [8:0]  M_LIMIT   = 9'd451;
	localparam logic [7:0]  T_APRIL   = 8'd124;  // t / 31 becomes 4 from here
	localparam logic [7:0]  T_OFS_APR = 8'd123;  // t % 31 + 1 in April
	localparam logic [7:0]  T_OFS_MAR = 8'd92;   // t % 31 + 1 in March

	logic [YEAR_W-1:0] year_s1;
	logic [CENT_W-1:0] q100_s1;
	logic [9:0]        q19_s1;

	logic [4:0]        a_s2, a_s3, a_s4, a_s5, a_s6, a_s7;
	logic [CENT_W-1:0] b_s2, b_s3;
	logic [YY_W-1:0]   c_s2, c_s3, c_s4, c_s5;
	logic [2:0]        f_s2;
	logic [5:0]        g_s3;
	logic [1:0]        e_s4, e_s5;
	logic [9:0]        hsum_s4, hsum_s5;
	logic [4:0]        q30_s5;
	logic [4:0]        h_s6, h_s7;
	logic [6:0]        lsum_s6, lsum_s7;
	logic [3:0]        ql_s7;
	logic [7:0]        t_s8;
	hdc_easter_t       easter_s9;

	logic [26:0] p100;
	logic [29:0] p19;
	logic [12:0] p25;
	logic [YEAR_W-1:0] rem19, rem100;
	logic [7:0]  gx;
	logic [14:0] p3;
	logic [9:0]  hsum_w;
	logic [18:0] p30;
	logic [9:0]  h_w;
	logic [7:0]  lsum_w;
	logic [13:0] p7;
	logic [6:0]  l_w;
	logic [8:0]  msum;
	logic [7:0]  t_w;

	// Stage 1: reciprocal products for /100 and /19
	always_comb begin
		p100 = 27'(year) * 27'(RCP100);
		p19  = 30'(year) * 30'(RCP19);
	end

	always_ff @(posedge clk) begin
		year_s1 <= year;
		q100_s1 <= p100[26:19];
		q19_s1  <= p19[29:20];
	end

	// Stage 2: remainders and f = (b + 8) / 25
	always_comb begin
		rem19  = year_s1 - 14'(q19_s1) * 14'd19;
		rem100 = year_s1 - 14'(q100_s1) * 14'd100;
		p25    = (13'(q100_s1) + 13'd8) * 13'(RCP25);
	end

	always_ff @(posedge clk) begin
		a_s2 <= rem19[4:0];
		b_s2 <= q100_s1;
		c_s2 <= rem100[YY_W-1:0];
		f_s2 <= p25[12:10];
	end

	// Stage 3: g = (b - f + 1) / 3
	always_comb begin
		gx = b_s2 - 8'(f_s2) + 8'd1;
		p3 = 15'(gx) * 15'(RCP3);
	end

	always_ff @(posedge clk) begin
		g_s3 <= p3[14:9];
		a_s3 <= a_s2;
		b_s3 <= b_s2;
		c_s3 <= c_s2;
	end

	// Stage 4: sum ahead of the mod-30 reduction
	always_comb begin
		hsum_w = 10'(a_s3) * 10'd19 + 10'(b_s3) + 10'd15 - 10'(b_s3[7:2]) - 10'(g_s3);
	end

	always_ff @(posedge clk) begin
		hsum_s4 <= hsum_w;
		a_s4    <= a_s3;
		c_s4    <= c_s3;
		e_s4    <= b_s3[1:0];
	end

	// Stage 5: quotient by 30
	always_comb begin
		p30 = 19'(hsum_s4) * 19'(RCP30);
	end

	always_ff @(posedge clk) begin
		q30_s5  <= p30[18:14];
		hsum_s5 <= hsum_s4;
		a_s5    <= a_s4;
		c_s5    <= c_s4;
		e_s5    <= e_s4;
	end

	// Stage 6: h, then the sum ahead of the mod-7 reduction
	always_comb begin
		h_w    = hsum_s5 - 10'(q30_s5) * 10'd30;
		lsum_w = 8'd32 + 8'({e_s5, 1'b0}) + 8'({c_s5[6:2], 1'b0})
			- 8'(h_w[4:0]) - 8'(c_s5[1:0]);
	end

	always_ff @(posedge clk) begin
		h_s6    <= h_w[4:0];
		lsum_s6 <= lsum_w[6:0];
		a_s6    <= a_s5;
	end

	// Stage 7: quotient by 7
	always_comb begin
		p7 = 14'(lsum_s6) * 14'(RCP7);
	end

	always_ff @(posedge clk) begin
		ql_s7   <= p7[13:10];
		lsum_s7 <= lsum_s6;
		h_s7    <= h_s6;
		a_s7    <= a_s6;
	end

	// Stage 8: l, the m correction and t
	always_comb begin
		l_w  = lsum_s7 - 7'(ql_s7) * 7'd7;
		msum = 9'(a_s7) + 9'(h_s7) * 9'd11 + 9'(l_w[2:0]) * 9'd22;
		t_w  = 8'(h_s7) + 8'(l_w[2:0]) + 8'd114 - ((msum >= M_LIMIT) ? 8'd7 : 8'd0);
	end

	always_ff @(posedge clk) begin
		t_s8 <= t_w;
	end

	// Stage 9: split t into month and day
	always_ff @(posedge clk) begin
		if (t_s8 >= T_APRIL) begin
			easter_s9.month <= EMON_APR;
			easter_s9.day   <= DAY_W'(t_s8 - T_OFS_APR);
		end else begin
			easter_s9.month <= EMON_MAR;
			easter_s9.day   <= DAY_W'(t_s8 - T_OFS_MAR);
		end
	end

	assign split  = '{cent: b_s2, yy: c_s2};
	assign easter = easter_s9;

endmodule

// ===== rtl/core/hdc_weekday.sv =====
// Zeller weekday pipeline giving the third Monday of January and second of October.
// Depends on hdc_pkg; takes the stage-2 year split and delivers at stage 9.
module hdc_weekday import hdc_pkg::*; (
	input  logic         clk,
	input  hdc_split_t   split,
	output hdc_mondays_t mondays
);

	localparam logic [10:0] RCP7 = 11'd1171;   // /7, shift 13

	// Days from the first of the month to its first Monday, by Zeller code
	function automatic logic [2:0] monday_offset(input logic [2:0] hz);
		logic [2:0] off;
		unique case (hz)
			3'd0:    off = 3'd2;
			3'd1:    off = 3'd1;
			3'd2:    off = 3'd0;
			3'd3:    off = 3'd6;
			3'd4:    off = 3'd5;
			3'd5:    off = 3'd4;
			3'd6:    off = 3'd3;
			default: off = 3'd0;
		endcase
		return off;
	endfunction

	logic [9:0]   so_s3, sj_s3, so_s4, sj_s4;
	logic [7:0]   qo_s4, qj_s4;
	hdc_mondays_t mon_s5, mon_s6, mon_s7, mon_s8, mon_s9;

	logic [YY_W-1:0]   kp;
	logic [CENT_W-1:0] jp;
	logic [20:0]       po, pj;
	logic [9:0]        ro, rj;

	// Stage 3: Zeller sums; January counts as month 13 of the previous year
	always_comb begin
		if (split.yy == '0) begin
			kp = 7'd99;
			jp = split.cent - 8'd1;
		end else begin
			kp = split.yy - 7'd1;
			jp = split.cent;
		end
	end

	always_ff @(posedge clk) begin
		so_s3 <= 10'd29 + 10'(split.yy) + 10'(split.yy[6:2]) + 10'(split.cent[7:2])
			+ 10'(split.cent) * 10'd5;
		sj_s3 <= 10'd37 + 10'(kp) + 10'(kp[6:2]) + 10'(jp[7:2]) + 10'(jp) * 10'd5;
	end

	// Stage 4: quotients by 7
	always_comb begin
		po = 21'(so_s3) * 21'(RCP7);
		pj = 21'(sj_s3) * 21'(RCP7);
	end

	always_ff @(posedge clk) begin
		qo_s4 <= po[20:13];
		qj_s4 <= pj[20:13];
		so_s4 <= so_s3;
		sj_s4 <= sj_s3;
	end

	// Stage 5: weekday codes and Monday dates
	always_comb begin
		ro = so_s4 - 10'(qo_s4) * 10'd7;
		rj = sj_s4 - 10'(qj_s4) * 10'd7;
	end

	always_ff @(posedge clk) begin
		mon_s5.mlk_day <= 5'd15 + 5'(monday_offset(rj[2:0]));
		mon_s5.idp_day <= 5'd8 + 5'(monday_offset(ro[2:0]));
	end

	// Stages 6 to 9: hold alongside the computus
	always_ff @(posedge clk) begin
		mon_s6 <= mon_s5;
		mon_s7 <= mon_s6;
		mon_s8 <= mon_s7;
		mon_s9 <= mon_s8;
	end

	assign mondays = mon_s9;

endmodule
